@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define LR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("line rasteriser check failed");

// Clocked check that also holds during reset.
`define LR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("line rasteriser reset check failed");

`endif

@@ sv/lr_pkg.sv @@
// Shared constants and types of the line rasteriser.
package lr_pkg;

    localparam int COORD_WIDTH_DEF = 14;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SIZE_W          = 13;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } frame_cfg_t;

endpackage

@@ sv/line_rasterizer_unit.sv @@
// Top level of the Bresenham line rasteriser with frame clipping.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  s_      | in        | s_tvalid / s_tready  | tuser: kind; tdata: start_x, start_y,
//          |           |                      |        end_x, end_y (lowest bits first)
//  m_      | out       | m_tvalid / m_tready  | tdata: pixel_x, pixel_y; tuser: inside_res;
//          |           |                      | tlast: last_pixel
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (frame width / height)
//
// One transaction per clock in steady state while m_ is not stalled: each step
// is a single add-compare update of the error term in the back end, so a pixel
// leaves every cycle. An accepted step is written into the queue at its
// accepting edge; its pixel enters the output register when the back end pops
// it, and m_ shows it from there. Reset (aresetn low, synchronous) empties the queue,
// drops any line in progress and restores the 640 x 480 frame size.
// A stalled m_ side stops the back end only; the front end keeps taking
// transactions until the queue fills. Load transactions and steps with no line
// active drain through the back end even while the output register is full.
module line_rasterizer_unit import lr_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,   // start_x, start_y, end_x, end_y
    input  logic                                   s_tuser,   // kind
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,   // pixel_x, pixel_y
    output logic                                   m_tuser,   // inside_res
    output logic                                   m_tlast,   // last_pixel
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                 cfg_index,
    input  logic [SIZE_W-1:0]                      cfg_data
);

    localparam int CW      = COORD_WIDTH;
    localparam int ENTRY_W = 7 * COORD_WIDTH + 6;
    localparam int MDATA_W = ((2*COORD_WIDTH+7)/8)*8;

    frame_cfg_t          frame_cfg_reg, frame_cfg_next;
    logic [ENTRY_W-1:0]  push_entry, pop_entry;
    logic                q_valid, q_ready;
    logic [CW-1:0]       px, py;

    // configuration register file; writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        frame_cfg_next = frame_cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_cfg_next.width  = cfg_data;
                REG_FRAME_HEIGHT: frame_cfg_next.height = cfg_data;
                default:          frame_cfg_next = frame_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cfg_reg.width  <= FRAME_WIDTH_RST;
            frame_cfg_reg.height <= FRAME_HEIGHT_RST;
        end else begin
            frame_cfg_reg <= frame_cfg_next;
        end
    end

    // front end: setup arithmetic for loads, straight into the queue
    lr_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .kind    (s_tuser),
        .start_x (s_tdata[CW-1:0]),
        .start_y (s_tdata[2*CW-1:CW]),
        .end_x   (s_tdata[3*CW-1:2*CW]),
        .end_y   (s_tdata[4*CW-1:3*CW]),
        .entry   (push_entry)
    );

    lr_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (push_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (pop_entry)
    );

    // back end: stepping engine plus output register
    lr_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_cfg  (frame_cfg_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (pop_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (px),
        .out_y      (py),
        .out_inside (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = MDATA_W'({py, px});

endmodule

@@ sv/lr_front.sv @@
// Front end: takes transactions, works out deltas, signs and start error.
module lr_front import lr_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     kind,
    input  logic [COORD_WIDTH-1:0]   start_x,
    input  logic [COORD_WIDTH-1:0]   start_y,
    input  logic [COORD_WIDTH-1:0]   end_x,
    input  logic [COORD_WIDTH-1:0]   end_y,
    output logic [7*COORD_WIDTH+5:0] entry
);

    localparam int CW    = COORD_WIDTH;
    localparam int ERR_W = COORD_WIDTH + 3;

    logic signed [CW:0]    diff_x;
    logic signed [CW:0]    diff_y;
    logic                  col_neg;
    logic                  row_neg;
    logic [CW-1:0]         delta_col;
    logic [CW-1:0]         delta_row;
    logic signed [ERR_W-1:0] err_init;

    always_comb begin
        diff_x    = (CW+1)'($signed(end_x)) - (CW+1)'($signed(start_x));
        diff_y    = (CW+1)'($signed(end_y)) - (CW+1)'($signed(start_y));
        col_neg   = !($signed(start_x) < $signed(end_x));
        row_neg   = !($signed(start_y) < $signed(end_y));
        delta_col = col_neg ? CW'(-diff_x) : CW'(diff_x);
        delta_row = row_neg ? CW'(-diff_y) : CW'(diff_y);
        err_init  = $signed(ERR_W'(delta_col)) - $signed(ERR_W'(delta_row));
    end

    // step items use only the kind; the rest is ignored downstream
    assign entry = {err_init, delta_row, delta_col, row_neg, col_neg,
                    end_y, end_x, start_y, start_x, kind};

endmodule

@@ sv/lr_queue.sv @@
// Small register FIFO between front and back end.
module lr_queue import lr_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/lr_back.sv @@
// Back end: line state, Bresenham step, clipping and the output register.
module lr_back import lr_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  frame_cfg_t               frame_cfg,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  logic [7*COORD_WIDTH+5:0] q_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COORD_WIDTH-1:0]   out_x,
    output logic [COORD_WIDTH-1:0]   out_y,
    output logic                     out_inside,
    output logic                     out_last
);

    localparam int CW    = COORD_WIDTH;
    localparam int ERR_W = COORD_WIDTH + 3;
    localparam int CMP_W = ((CW > SIZE_W) ? CW : SIZE_W) + 1;

    // unpacked queue entry
    logic                    e_kind;
    logic [CW-1:0]           e_sx, e_sy, e_ex, e_ey;
    logic                    e_cneg, e_rneg;
    logic [CW-1:0]           e_dc, e_dr;
    logic signed [ERR_W-1:0] e_err;

    assign {e_err, e_dr, e_dc, e_rneg, e_cneg, e_ey, e_ex, e_sy, e_sx, e_kind} = q_data;

    logic [CW-1:0]           cur_col_reg, cur_col_next;
    logic [CW-1:0]           cur_row_reg, cur_row_next;
    logic [CW-1:0]           goal_col_reg, goal_col_next;
    logic [CW-1:0]           goal_row_reg, goal_row_next;
    logic                    col_neg_reg, col_neg_next;
    logic                    row_neg_reg, row_neg_next;
    logic [CW-1:0]           delta_col_reg, delta_col_next;
    logic [CW-1:0]           delta_row_reg, delta_row_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic                    busy_reg, busy_next;

    logic                    valid_reg, valid_next;
    logic [CW-1:0]           x_reg, x_next, y_reg, y_next;
    logic                    inside_reg, inside_next, last_reg, last_next;

    logic                    out_free, pop, emit, at_goal, in_frame;
    logic                    col_move, row_move;
    logic signed [ERR_W-1:0] e2, dc_ext, dr_ext;

    assign out_free = !valid_reg || out_ready;
    // loads and idle steps never need the output slot
    assign q_ready  = (e_kind == KIND_LOAD) || !busy_reg || out_free;
    assign pop      = q_valid && q_ready;
    assign emit     = pop && (e_kind == KIND_STEP) && busy_reg;

    assign at_goal  = (cur_col_reg == goal_col_reg) && (cur_row_reg == goal_row_reg);
    assign in_frame = !cur_col_reg[CW-1] && !cur_row_reg[CW-1] &&
                      (CMP_W'(cur_col_reg) < CMP_W'(frame_cfg.width)) &&
                      (CMP_W'(cur_row_reg) < CMP_W'(frame_cfg.height));

    assign dc_ext   = $signed(ERR_W'(delta_col_reg));
    assign dr_ext   = $signed(ERR_W'(delta_row_reg));
    assign e2       = err_reg <<< 1;
    assign col_move = (e2 >= -dr_ext);
    assign row_move = (e2 <= dc_ext);

    always_comb begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        goal_col_next  = goal_col_reg;
        goal_row_next  = goal_row_reg;
        col_neg_next   = col_neg_reg;
        row_neg_next   = row_neg_reg;
        delta_col_next = delta_col_reg;
        delta_row_next = delta_row_reg;
        err_next       = err_reg;
        busy_next      = busy_reg;

        if (pop && (e_kind == KIND_LOAD)) begin
            cur_col_next   = e_sx;
            cur_row_next   = e_sy;
            goal_col_next  = e_ex;
            goal_row_next  = e_ey;
            col_neg_next   = e_cneg;
            row_neg_next   = e_rneg;
            delta_col_next = e_dc;
            delta_row_next = e_dr;
            err_next       = e_err;
            busy_next      = 1'b1;
        end else if (emit) begin
            if (at_goal) begin
                busy_next = 1'b0;
            end else begin
                err_next = err_reg - (col_move ? dr_ext : '0) + (row_move ? dc_ext : '0);
                if (col_move) begin
                    cur_col_next = cur_col_reg + (col_neg_reg ? '1 : CW'(1));
                end
                if (row_move) begin
                    cur_row_next = cur_row_reg + (row_neg_reg ? '1 : CW'(1));
                end
            end
        end
    end

    always_comb begin
        valid_next  = emit ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        x_next      = emit ? cur_col_reg : x_reg;
        y_next      = emit ? cur_row_reg : y_reg;
        inside_next = emit ? in_frame : inside_reg;
        last_next   = emit ? at_goal : last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_col_reg   <= cur_col_next;
        cur_row_reg   <= cur_row_next;
        goal_col_reg  <= goal_col_next;
        goal_row_reg  <= goal_row_next;
        col_neg_reg   <= col_neg_next;
        row_neg_reg   <= row_neg_next;
        delta_col_reg <= delta_col_next;
        delta_row_reg <= delta_row_next;
        err_reg       <= err_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        inside_reg    <= inside_next;
        last_reg      <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_inside = inside_reg;
    assign out_last   = last_reg;

endmodule

@@ sv/lr_checker.sv @@
// Port-level checker for the line rasteriser, bound to the top level.
`include "assert_macros.svh"

module lr_checker import lr_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic                               m_tuser,
    input logic                               m_tlast
);

    // a pixel held under back-pressure keeps its coordinates and flags
    `LR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // reset leaves no pixel pending
    `LR_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid)

    // a clipped-in pixel never has a negative coordinate
    `LR_ASSERT(a_inside_nonneg, m_tvalid && m_tuser |-> !m_tdata[COORD_WIDTH-1] && !m_tdata[2*COORD_WIDTH-1])

    // no pixel can leave the cycle after reset, even with input offered
    `LR_ASSERT_ALWAYS(a_no_early_pixel, !aresetn ##1 aresetn |-> !m_tvalid)

endmodule

bind line_rasterizer_unit lr_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
